>>> rtl/multi_channel_linear_fader_core_macros.svh
// Assertion macros for the fader RTL, used by mclf_back.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef MULTI_CHANNEL_LINEAR_FADER_CORE_MACROS_SVH
`define MULTI_CHANNEL_LINEAR_FADER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MCLF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define MCLF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mclf_pkg.sv
// Shared types and constants of the multi-channel linear fader.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mclf_pkg;

  localparam int CH_W     = 4;   // channel field
  localparam int LVL_W    = 16;  // fixed-point level and increment
  localparam int STEP_W   = 8;   // step count
  localparam int TGT_W    = 15;  // target times scale, scale up to 128
  localparam int DIFF_W   = 18;  // signed target minus level
  localparam int MAG_W    = 17;  // magnitude of the difference
  localparam int ADDR_W   = 8;
  localparam int VAL_W    = 8;
  localparam int DIV_STEPS = 17;

  // Reciprocal divide by the scale: q0 = (m * floor(2^K / scale)) >> K
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 24;
  localparam int PROD_W      = LVL_W + RECIP_W;

  localparam logic [ADDR_W-1:0] PWM_BASE_RST = 8'h02;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [ADDR_W-1:0] CHAN_REMAP [16] = '{
    8'h01, 8'h03, 8'h05, 8'h06, 8'h08, 8'h0A, 8'h0C, 8'h0E,
    8'h00, 8'h02, 8'h04, 8'h07, 8'h09, 8'h0B, 8'h0D, 8'h0F
  };

  typedef enum logic [0:0] {
    CMD_SET  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [CH_W-1:0]       ch;
    logic [TGT_W-1:0]      tgt;
    logic [STEP_W-1:0]     steps;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_WAIT,
    ST_TICK_SCAN,
    ST_TICK_MUL,
    ST_TICK_FIX,
    ST_TICK_NONE
  } fsm_e;

endpackage

>>> rtl/mclf_front.sv
// Front end: decodes stream requests into queue commands.
// Depends on mclf_pkg.
`timescale 1ns / 1ps

module mclf_front #(
  parameter int CHANNELS       = 16,
  parameter int FRACTION_SCALE = 64
) (
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [19:0]        s_data_i,   // channel[3:0], target[11:4], steps[19:12]
  input  logic               s_op_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output mclf_pkg::cmd_t     cmd_o
);

  logic [mclf_pkg::CH_W-1:0]   ch;
  logic [7:0]                  target;
  logic [mclf_pkg::STEP_W-1:0] steps;
  logic                        drop;

  assign ch     = s_data_i[3:0];
  assign target = s_data_i[11:4];
  assign steps  = s_data_i[19:12];

  // Drop set requests aimed past the last channel.
  assign drop = (s_op_i == mclf_pkg::OP_SET) && ({1'b0, ch} >= 5'(CHANNELS));

  always_comb begin
    cmd_o.kind  = (s_op_i == mclf_pkg::OP_TICK) ? mclf_pkg::CMD_TICK : mclf_pkg::CMD_SET;
    cmd_o.ch    = ch;
    cmd_o.tgt   = mclf_pkg::TGT_W'(target * FRACTION_SCALE);
    cmd_o.steps = (steps == '0) ? mclf_pkg::STEP_W'(1) : steps;
  end

  assign cmd_valid_o = s_valid_i && !drop;
  assign s_ready_o   = cmd_ready_i || drop;

endmodule

>>> rtl/mclf_cmd_fifo.sv
// Two-entry command queue between front and back end.
// Depends on mclf_pkg.
`timescale 1ns / 1ps

module mclf_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  mclf_pkg::cmd_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output mclf_pkg::cmd_t rd_data_o
);

  mclf_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> rtl/mclf_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on mclf_pkg.
`timescale 1ns / 1ps

module mclf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mclf_pkg::MAG_W-1:0]   dividend_i,
  input  logic [mclf_pkg::STEP_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [mclf_pkg::MAG_W-1:0]   quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [4:0]                    cnt_q, cnt_d;
  logic [mclf_pkg::MAG_W-1:0]    dvd_q, dvd_d;
  logic [mclf_pkg::STEP_W-1:0]   rem_q, rem_d;
  logic [mclf_pkg::STEP_W-1:0]   dsr_q, dsr_d;
  logic [mclf_pkg::STEP_W:0]     trial;
  logic                          ge;

  assign trial = {rem_q, dvd_q[mclf_pkg::MAG_W-1]};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'(mclf_pkg::DIV_STEPS);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // Shift in the next dividend bit and keep the remainder below the divisor.
      rem_d = ge ? mclf_pkg::STEP_W'(trial - {1'b0, dsr_q})
                 : trial[mclf_pkg::STEP_W-1:0];
      dvd_d = {dvd_q[mclf_pkg::MAG_W-2:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

>>> rtl/mclf_back.sv
// Back end: channel state, set-target division and tick scan with result register.
// Depends on mclf_pkg, mclf_div and the assertion macro header.
`timescale 1ns / 1ps
`include "multi_channel_linear_fader_core_macros.svh"

module mclf_back #(
  parameter int CHANNELS       = 16,
  parameter int FRACTION_SCALE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  mclf_pkg::cmd_t               cmd_i,
  input  logic [mclf_pkg::ADDR_W-1:0]  pwm_base_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mclf_pkg::ADDR_W-1:0]  out_addr_o,
  output logic [mclf_pkg::VAL_W-1:0]   out_value_o,
  output logic                         out_updated_o,
  output logic                         out_last_o
);

  localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_IW-1:0] LAST_CH = CH_IW'(CHANNELS - 1);
  localparam logic [mclf_pkg::RECIP_W-1:0] RECIP =
    mclf_pkg::RECIP_W'((64'd1 << mclf_pkg::RECIP_SHIFT) / FRACTION_SCALE);

  mclf_pkg::fsm_e state_q, state_d;

  logic [mclf_pkg::LVL_W-1:0]   level_q [CHANNELS];
  logic [mclf_pkg::LVL_W-1:0]   inc_q   [CHANNELS];
  logic [mclf_pkg::STEP_W-1:0]  left_q  [CHANNELS];
  logic [CHANNELS-1:0]          act;
  logic                         hi_active;

  logic [CH_IW-1:0]             ch_q;
  logic [mclf_pkg::STEP_W-1:0]  steps_q;
  logic                         neg_q;
  logic                         last_q;
  logic [mclf_pkg::LVL_W-1:0]   lvl_q;
  logic [mclf_pkg::LVL_W-1:0]   mag_q;
  logic [mclf_pkg::PROD_W-1:0]  prod_q;

  logic                         out_valid_q;
  logic [mclf_pkg::ADDR_W-1:0]  out_addr_q;
  logic [mclf_pkg::VAL_W-1:0]   out_value_q;
  logic                         out_updated_q;
  logic                         out_last_q;

  // Control strobes
  logic out_free, pop, pop_set, pop_tick, set_wr, tick_wr, mul_en, ch_adv, out_fix, out_none;

  // Set-target datapath
  logic [CH_IW-1:0]             set_ch;
  logic [mclf_pkg::LVL_W-1:0]   set_lvl;
  logic [mclf_pkg::DIFF_W-1:0]  diff;
  logic [mclf_pkg::MAG_W-1:0]   diff_mag;
  logic                         div_done;
  logic [mclf_pkg::MAG_W-1:0]   quo;
  logic [mclf_pkg::LVL_W-1:0]   new_inc;

  // Tick datapath
  logic [mclf_pkg::LVL_W-1:0]   new_lvl;
  logic [mclf_pkg::LVL_W-1:0]   lvl_mag;
  logic [mclf_pkg::LVL_W-1:0]   q0;
  logic [mclf_pkg::MAG_W-1:0]   q0_back;
  logic [mclf_pkg::MAG_W-1:0]   rem;
  logic [mclf_pkg::LVL_W-1:0]   qf;
  logic [mclf_pkg::VAL_W-1:0]   pwm_val;
  logic [mclf_pkg::ADDR_W-1:0]  pwm_addr;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      act[i] = (left_q[i] != '0);
    end
    hi_active = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if ((i > int'(ch_q)) && act[i]) begin
        hi_active = 1'b1;
      end
    end
  end

  assign set_ch   = cmd_i.ch[CH_IW-1:0];
  assign set_lvl  = level_q[set_ch];
  assign diff     = $signed({3'b000, cmd_i.tgt}) - $signed({{2{set_lvl[15]}}, set_lvl});
  assign diff_mag = diff[mclf_pkg::DIFF_W-1] ? mclf_pkg::MAG_W'(-diff)
                                             : diff[mclf_pkg::MAG_W-1:0];
  assign new_inc  = neg_q ? mclf_pkg::LVL_W'(16'd0 - quo[mclf_pkg::LVL_W-1:0])
                          : quo[mclf_pkg::LVL_W-1:0];

  assign new_lvl  = level_q[ch_q] + inc_q[ch_q];
  assign lvl_mag  = lvl_q[15] ? mclf_pkg::LVL_W'(16'd0 - lvl_q) : lvl_q;

  // Reciprocal estimate is low by at most one; one compare fixes it.
  assign q0       = prod_q[mclf_pkg::RECIP_SHIFT +: mclf_pkg::LVL_W];
  assign q0_back  = mclf_pkg::MAG_W'(q0 * FRACTION_SCALE);
  assign rem      = {1'b0, mag_q} - q0_back;
  assign qf       = (rem >= mclf_pkg::MAG_W'(FRACTION_SCALE)) ? q0 + 16'd1 : q0;
  assign pwm_val  = neg_q ? 8'(8'd0 - qf[7:0]) : qf[7:0];
  assign pwm_addr = 8'(pwm_base_i + mclf_pkg::CHAN_REMAP[4'(ch_q)]);

  assign out_free = !out_valid_q || out_ready_i;

  mclf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (pop_set),
    .dividend_i (diff_mag),
    .divisor_i  (cmd_i.steps),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mclf_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == mclf_pkg::CMD_SET) begin
            state_d = mclf_pkg::ST_SET_WAIT;
          end else if (act == '0) begin
            state_d = mclf_pkg::ST_TICK_NONE;
          end else begin
            state_d = mclf_pkg::ST_TICK_SCAN;
          end
        end
      end
      mclf_pkg::ST_SET_WAIT: begin
        if (div_done) state_d = mclf_pkg::ST_IDLE;
      end
      mclf_pkg::ST_TICK_SCAN: begin
        if (act[ch_q]) state_d = mclf_pkg::ST_TICK_MUL;
      end
      mclf_pkg::ST_TICK_MUL: begin
        state_d = mclf_pkg::ST_TICK_FIX;
      end
      mclf_pkg::ST_TICK_FIX: begin
        if (out_free) state_d = last_q ? mclf_pkg::ST_IDLE : mclf_pkg::ST_TICK_SCAN;
      end
      mclf_pkg::ST_TICK_NONE: begin
        if (out_free) state_d = mclf_pkg::ST_IDLE;
      end
      default: state_d = mclf_pkg::ST_IDLE;
    endcase
  end

  // Strobes
  always_comb begin
    pop      = 1'b0;
    set_wr   = 1'b0;
    tick_wr  = 1'b0;
    mul_en   = 1'b0;
    ch_adv   = 1'b0;
    out_fix  = 1'b0;
    out_none = 1'b0;
    case (state_q)
      mclf_pkg::ST_IDLE:      pop     = 1'b1;
      mclf_pkg::ST_SET_WAIT:  set_wr  = div_done;
      mclf_pkg::ST_TICK_SCAN: begin
        tick_wr = act[ch_q];
        ch_adv  = !act[ch_q];
      end
      mclf_pkg::ST_TICK_MUL:  mul_en  = 1'b1;
      mclf_pkg::ST_TICK_FIX: begin
        out_fix = out_free;
        ch_adv  = out_free && !last_q;
      end
      mclf_pkg::ST_TICK_NONE: out_none = out_free;
      default: pop = 1'b0;
    endcase
  end

  assign cmd_ready_o = pop;
  assign pop_set     = pop && cmd_valid_i && (cmd_i.kind == mclf_pkg::CMD_SET);
  assign pop_tick    = pop && cmd_valid_i && (cmd_i.kind == mclf_pkg::CMD_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mclf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Channel state clears to zero at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        level_q[i] <= '0;
        inc_q[i]   <= '0;
        left_q[i]  <= '0;
      end
    end else if (set_wr) begin
      inc_q[ch_q]  <= new_inc;
      left_q[ch_q] <= steps_q;
    end else if (tick_wr) begin
      level_q[ch_q] <= new_lvl;
      left_q[ch_q]  <= left_q[ch_q] - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else if (pop_set) begin
      ch_q <= set_ch;
    end else if (pop_tick) begin
      ch_q <= '0;
    end else if (ch_adv) begin
      ch_q <= CH_IW'(ch_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_set) begin
      steps_q <= cmd_i.steps;
      neg_q   <= diff[mclf_pkg::DIFF_W-1];
    end
    if (tick_wr) begin
      lvl_q  <= new_lvl;
      last_q <= !hi_active;
    end
    if (mul_en) begin
      mag_q  <= lvl_mag;
      neg_q  <= lvl_q[15];
      prod_q <= lvl_mag * RECIP;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_fix || out_none) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fix) begin
      out_addr_q    <= pwm_addr;
      out_value_q   <= pwm_val;
      out_updated_q <= 1'b1;
      out_last_q    <= last_q;
    end else if (out_none) begin
      out_addr_q    <= '0;
      out_value_q   <= '0;
      out_updated_q <= 1'b0;
      out_last_q    <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_addr_o    = out_addr_q;
  assign out_value_o   = out_value_q;
  assign out_updated_o = out_updated_q;
  assign out_last_o    = out_last_q;

  `MCLF_ASSERT_IMP(a_div_done_in_wait, div_done, state_q == mclf_pkg::ST_SET_WAIT, "divider done outside set wait")
  `MCLF_ASSERT_IMP(a_scan_has_work, state_q == mclf_pkg::ST_TICK_SCAN, act != '0, "tick scan with no active channel")
  `MCLF_ASSERT_IMP(a_last_ch_active, (state_q == mclf_pkg::ST_TICK_SCAN) && (ch_q == LAST_CH), act[ch_q], "scan reached last channel without work")
  `MCLF_ASSERT_NXT(a_last_ends_tick, out_fix && last_q, state_q == mclf_pkg::ST_IDLE, "tick did not end after its last result")

endmodule

>>> rtl/multi_channel_linear_fader_core.sv
// Top level of the multi-channel linear fader: config register, stream packing.
// Depends on mclf_pkg, mclf_front, mclf_cmd_fifo and mclf_back.
//
// Usage:
//   Input stream s_axis: tuser selects the request (0 set target, 1 tick);
//   tdata carries channel, target and step count. A set target loads one
//   channel's increment and step count and gives no result. A tick steps
//   every channel with steps left and sends one result per stepped channel
//   on m_axis, tlast on the final one; tuser is 0 on the single result of a
//   tick that stepped nothing.
//   cfg_we_i / cfg_wdata_i write the base address of the PWM registers.
//   Timing: a set target holds the back end while it is taken, through 17
//   serial divider steps and while the result is stored. A tick scans each
//   channel up to its last active channel and adds a multiply and a correction
//   step for the divide by the scale per active channel; a tick with no active
//   channel goes straight to its single result. A two-entry queue takes new
//   requests while the back end works.
//   Reset clears all channel levels, increments and step counts, empties the
//   queue and sets the base address to 2. When m_axis_tready_i is low the
//   result register holds, the scan halts, and the queue fills and then
//   drops s_axis_tready_o.
`timescale 1ns / 1ps

module multi_channel_linear_fader_core #(
  parameter int CHANNELS       = 16,
  parameter int FRACTION_SCALE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // channel[3:0], target[11:4], steps[19:12], zero
  input  logic        s_axis_tuser_i,   // operation[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // reg_address[7:0], pwm_value[15:8]
  output logic        m_axis_tuser_o,   // updated[0]
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic [mclf_pkg::ADDR_W-1:0] pwm_base_q;

  logic           fr_valid, fr_ready;
  mclf_pkg::cmd_t fr_cmd;
  logic           q_valid, q_ready;
  mclf_pkg::cmd_t q_cmd;

  logic [mclf_pkg::ADDR_W-1:0] out_addr;
  logic [mclf_pkg::VAL_W-1:0]  out_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_base_q <= mclf_pkg::PWM_BASE_RST;
    end else if (cfg_we_i) begin
      pwm_base_q <= cfg_wdata_i;
    end
  end

  mclf_front #(
    .CHANNELS       (CHANNELS),
    .FRACTION_SCALE (FRACTION_SCALE)
  ) u_front (
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i[19:0]),
    .s_op_i      (s_axis_tuser_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  mclf_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_cmd),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_cmd)
  );

  mclf_back #(
    .CHANNELS       (CHANNELS),
    .FRACTION_SCALE (FRACTION_SCALE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_ready_o   (q_ready),
    .cmd_i         (q_cmd),
    .pwm_base_i    (pwm_base_q),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_addr_o    (out_addr),
    .out_value_o   (out_value),
    .out_updated_o (m_axis_tuser_o),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {out_value, out_addr};

endmodule
